/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the dual-wheel PID block.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication, disabled while reset is held low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/dipid_pkg.sv */
// Package of the dual-wheel incremental PID: register indexes, reset values,
// default parameters and the configuration struct. Depends on nothing.
package dipid_pkg;

    // Default parameter values
    localparam int SPEED_BITS_DEF     = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Width of the gains, clamps and drive outputs
    localparam int DRIVE_BITS = 16;
    localparam int CFG_ADDR_BITS = 3;

    // Configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DRIVE_MAX = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DRIVE_MIN = 3'd4;

    // Reset values of the configuration registers
    localparam logic [DRIVE_BITS-1:0] GAIN_P_RST    = 16'd7680;
    localparam logic [DRIVE_BITS-1:0] GAIN_I_RST    = 16'd1280;
    localparam logic [DRIVE_BITS-1:0] GAIN_D_RST    = 16'd0;
    localparam logic [DRIVE_BITS-1:0] DRIVE_MAX_RST = 16'd6500;
    localparam logic [DRIVE_BITS-1:0] DRIVE_MIN_RST = 16'd2500;

    // Configuration seen by both wheel datapaths
    typedef struct packed {
        logic [DRIVE_BITS-1:0] gain_p;
        logic [DRIVE_BITS-1:0] gain_i;
        logic [DRIVE_BITS-1:0] gain_d;
        logic [DRIVE_BITS-1:0] drive_max;
        logic [DRIVE_BITS-1:0] drive_min;
    } t_cfg;

endpackage

/* src/dipid_wheel.sv */
// One wheel of the incremental PID: error history, previous drive and the
// single-pass increment, truncation and clamp logic. Depends on dipid_pkg.
module dipid_wheel import dipid_pkg::*; #(
    parameter int SPEED_BITS     = SPEED_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  logic                         i_adv,
    input  logic signed [SPEED_BITS-1:0] i_target,
    input  logic signed [SPEED_BITS-1:0] i_measured,
    output logic [DRIVE_BITS-1:0]        o_drive
);

    // Width of the exact total, with headroom for the scaled previous drive
    localparam int PW = SPEED_BITS + 20;
    localparam int DW = DRIVE_BITS + GAIN_FRAC_BITS + 1;
    localparam int TW = ((PW > DW) ? PW : DW) + 2;
    localparam logic [TW-1:0] RND = TW'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    logic [DRIVE_BITS-1:0]        r_prev;
    logic signed [SPEED_BITS:0]   r_e1;
    logic signed [SPEED_BITS:0]   r_e2;

    logic signed [SPEED_BITS:0]   w_err;
    logic signed [SPEED_BITS+1:0] w_dp;
    logic signed [SPEED_BITS+2:0] w_dd;
    logic signed [DRIVE_BITS:0]   w_kp;
    logic signed [DRIVE_BITS:0]   w_ki;
    logic signed [DRIVE_BITS:0]   w_kd;
    logic signed [PW-1:0]         w_pp;
    logic signed [PW-1:0]         w_pi;
    logic signed [PW-1:0]         w_pd;
    logic signed [TW-1:0]         w_prev_s;
    logic signed [TW-1:0]         w_tot;
    logic signed [TW-1:0]         w_adj;
    logic signed [TW-1:0]         w_q;
    logic signed [TW-1:0]         w_max;
    logic signed [TW-1:0]         w_min;
    logic signed [TW-1:0]         w_hi;
    logic signed [TW-1:0]         w_lo;

    // Error and its first and second differences
    always_comb begin
        w_err = (SPEED_BITS+1)'(i_target) - (SPEED_BITS+1)'(i_measured);
        w_dp  = (SPEED_BITS+2)'(w_err) - (SPEED_BITS+2)'(r_e1);
        w_dd  = (SPEED_BITS+3)'(w_err) + (SPEED_BITS+3)'(r_e2)
              - ((SPEED_BITS+3)'(r_e1) <<< 1);
    end

    // Gains are unsigned; a zero top bit lets them join signed products
    assign w_kp = $signed({1'b0, i_cfg.gain_p});
    assign w_ki = $signed({1'b0, i_cfg.gain_i});
    assign w_kd = $signed({1'b0, i_cfg.gain_d});

    // The three gain products work side by side
    always_comb begin
        w_pp = PW'(w_dp) * PW'(w_kp);
        w_pi = PW'(w_err) * PW'(w_ki);
        w_pd = PW'(w_dd) * PW'(w_kd);
    end

    // Exact total, then division by the gain scale truncating toward zero
    always_comb begin
        w_prev_s = $signed(TW'(r_prev) << GAIN_FRAC_BITS);
        w_tot    = TW'(w_pp) + TW'(w_pi) + TW'(w_pd) + w_prev_s;
        w_adj    = w_tot + (w_tot[TW-1] ? $signed(RND) : $signed(TW'(0)));
        w_q      = w_adj >>> GAIN_FRAC_BITS;
    end

    // Upper clamp first, then lower, so crossed clamps give the minimum
    always_comb begin
        w_max   = $signed(TW'(i_cfg.drive_max));
        w_min   = $signed(TW'(i_cfg.drive_min));
        w_hi    = (w_q > w_max) ? w_max : w_q;
        w_lo    = (w_hi < w_min) ? w_min : w_hi;
        o_drive = w_lo[DRIVE_BITS-1:0];
    end

    // History moves on only when the request passes to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_e1   <= '0;
            r_e2   <= '0;
        end else if (i_adv) begin
            r_prev <= o_drive;
            r_e2   <= r_e1;
            r_e1   <= w_err;
        end
    end

endmodule

/* src/dual_incremental_pid_speed.sv */
// Dual-wheel incremental PID speed controller, top level.
// Streaming request channels in and out, one item per cycle unless the
// receiver stalls, with a configuration write port.
//
// Use: each input request on the s-side carries the left and right speed
// setpoints and measured encoder speeds; each output request on the m-side
// carries the new clamped PWM drive of both motors. Gains and drive clamps
// are written through the configuration port (index 0 gain_p, 1 gain_i,
// 2 gain_d, 3 drive_max, 4 drive_min; other indexes are ignored), which is
// always ready and must only be written while no request is in flight.
// Path: an input request that is accepted lands in the input register; its
// result is loaded into the output register, raising m_axis_tvalid, once
// the output register is empty or being emptied.
// Throughput: one request per cycle unless the receiver stalls; the gain
// multipliers, adder and clamp between the two registers are combinational.
// Reset loads the default gains and clamps and clears the drive and error
// history of both wheels. When the receiver stalls, the output register
// holds its result; the input register still takes one more request, then
// s_axis_tready falls until the output drains.
`include "assert_macros.svh"

module dual_incremental_pid_speed import dipid_pkg::*; #(
    parameter int SPEED_BITS     = SPEED_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // fields from bit 0: target_left, target_right, measured_left,
    // measured_right, each SPEED_BITS signed, zero padded to whole bytes
    input  logic [((4*SPEED_BITS+7)/8)*8-1:0]    s_axis_tdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // fields from bit 0: drive_left [15:0], drive_right [31:16]
    output logic [2*DRIVE_BITS-1:0]              m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [CFG_ADDR_BITS-1:0]             i_cfg_addr,
    input  logic [DRIVE_BITS-1:0]                i_cfg_data
);

    t_cfg                          r_cfg;
    logic                          r_in_vld;
    logic signed [SPEED_BITS-1:0]  r_tgt_l;
    logic signed [SPEED_BITS-1:0]  r_tgt_r;
    logic signed [SPEED_BITS-1:0]  r_meas_l;
    logic signed [SPEED_BITS-1:0]  r_meas_r;
    logic                          r_out_vld;
    logic [DRIVE_BITS-1:0]         r_drv_l;
    logic [DRIVE_BITS-1:0]         r_drv_r;
    logic                          w_adv;
    logic [DRIVE_BITS-1:0]         w_drv_l;
    logic [DRIVE_BITS-1:0]         w_drv_r;

    // Configuration registers, written one index per request
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p    <= GAIN_P_RST;
            r_cfg.gain_i    <= GAIN_I_RST;
            r_cfg.gain_d    <= GAIN_D_RST;
            r_cfg.drive_max <= DRIVE_MAX_RST;
            r_cfg.drive_min <= DRIVE_MIN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_addr)
                REG_GAIN_P:    r_cfg.gain_p    <= i_cfg_data;
                REG_GAIN_I:    r_cfg.gain_i    <= i_cfg_data;
                REG_GAIN_D:    r_cfg.gain_d    <= i_cfg_data;
                REG_DRIVE_MAX: r_cfg.drive_max <= i_cfg_data;
                REG_DRIVE_MIN: r_cfg.drive_min <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Flow control: the input register moves on whenever the output
    // register is empty or being emptied this cycle
    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_tgt_l  <= s_axis_tdata[SPEED_BITS-1:0];
            r_tgt_r  <= s_axis_tdata[2*SPEED_BITS-1:SPEED_BITS];
            r_meas_l <= s_axis_tdata[3*SPEED_BITS-1:2*SPEED_BITS];
            r_meas_r <= s_axis_tdata[4*SPEED_BITS-1:3*SPEED_BITS];
        end
    end

    // Wheel datapaths
    dipid_wheel #(
        .SPEED_BITS     (SPEED_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_wheel_l (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_adv      (w_adv),
        .i_target   (r_tgt_l),
        .i_measured (r_meas_l),
        .o_drive    (w_drv_l)
    );

    dipid_wheel #(
        .SPEED_BITS     (SPEED_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_wheel_r (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_adv      (w_adv),
        .i_target   (r_tgt_r),
        .i_measured (r_meas_r),
        .o_drive    (w_drv_r)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_drv_l <= w_drv_l;
            r_drv_r <= w_drv_r;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_drv_r, r_drv_l};

    // A result that passes on lies inside ordered clamps
    `ASSERT_IMPL(a_clamp_l, i_clk, i_rst_n,
        w_adv && (r_cfg.drive_min <= r_cfg.drive_max),
        (w_drv_l >= r_cfg.drive_min) && (w_drv_l <= r_cfg.drive_max),
        "left drive outside clamps")
    `ASSERT_IMPL(a_clamp_r, i_clk, i_rst_n,
        w_adv && (r_cfg.drive_min <= r_cfg.drive_max),
        (w_drv_r >= r_cfg.drive_min) && (w_drv_r <= r_cfg.drive_max),
        "right drive outside clamps")
    // Crossed clamps always give the minimum
    `ASSERT_IMPL(a_crossed, i_clk, i_rst_n,
        w_adv && (r_cfg.drive_min > r_cfg.drive_max),
        (w_drv_l == r_cfg.drive_min) && (w_drv_r == r_cfg.drive_min),
        "crossed clamps did not give the minimum")
    // A request that moves on appears at the output the next cycle
    `ASSERT_CLK(a_adv_out, i_clk, i_rst_n, w_adv |=> m_axis_tvalid,
        "advanced request missing at output")
    // Both registers full and stalled means no new request is taken
    `ASSERT_IMPL(a_full_stall, i_clk, i_rst_n,
        r_in_vld && r_out_vld && !m_axis_tready, !s_axis_tready,
        "request taken while full and stalled")

endmodule
